// ===== rtl/odk_pkg.sv =====
// Package: shared types, constants and tables for the omni drive odometry core.
package odk_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

   localparam logic [15:0] INV_WHEEL_RADIUS_RESET = 16'd6400;
   localparam logic [15:0] BASE_RADIUS_RESET = 16'd8651;
   localparam logic signed [17:0] COEF_SQRT3_HALF = 18'sd56756;
   localparam logic signed [17:0] COEF_HALF = 18'sd32768;
   localparam logic signed [16:0] CORDIC_COMP = 17'sd39797;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

   localparam logic ACTION_COMMAND = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic CSR_INV_WHEEL_RADIUS = 1'b0;
   localparam logic CSR_BASE_RADIUS = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WHEEL_A,
      ST_WHEEL_B,
      ST_WHEEL_C,
      ST_WHEEL_SCALE,
      ST_ODO_LOAD,
      ST_ODO_CORDIC,
      ST_ODO_MUL_X,
      ST_ODO_MUL_Y,
      ST_ODO_HEAD,
      ST_ODO_HEAD_RND,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CMD_LOAD,
      OP_WHEEL_SUM,
      OP_WHEEL_SCALE,
      OP_ODO_LOAD,
      OP_CORDIC_STEP,
      OP_POS_X,
      OP_POS_Y,
      OP_HEAD_MUL,
      OP_HEAD_ADD,
      OP_SEND
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [1:0]       wheel;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic out_busy;
   } status_type;

   function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
      logic signed [33:0] r;
      begin
         unique case (idx)
            5'd0: r = 34'sd536870912;
            5'd1: r = 34'sd316933405;
            5'd2: r = 34'sd167458907;
            5'd3: r = 34'sd85004756;
            5'd4: r = 34'sd42667331;
            5'd5: r = 34'sd21354465;
            5'd6: r = 34'sd10679838;
            5'd7: r = 34'sd5340245;
            5'd8: r = 34'sd2670163;
            5'd9: r = 34'sd1335086;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41721;
            5'd15: r = 34'sd20860;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2607;
            5'd19: r = 34'sd1303;
            5'd20: r = 34'sd651;
            5'd21: r = 34'sd325;
            5'd22: r = 34'sd162;
            5'd23: r = 34'sd81;
            default: r = 34'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/odk_if.sv =====
// Interfaces: request and response channels of the odometry core.
interface odk_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] vel_x;
   logic [15:0] vel_y;
   logic [15:0] turn_rate;
   logic [15:0] elapsed;
   modport source (output valid, action, vel_x, vel_y, turn_rate, elapsed, input ready);
   modport sink (input valid, action, vel_x, vel_y, turn_rate, elapsed, output ready);
endinterface

interface odk_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [23:0] wheel_speed_a;
   logic [23:0] wheel_speed_b;
   logic [23:0] wheel_speed_c;
   logic [31:0] pose_x;
   logic [31:0] pose_y;
   logic [15:0] heading;
   modport source (output valid, result_kind, wheel_speed_a, wheel_speed_b, wheel_speed_c,
                   pose_x, pose_y, heading, input ready);
   modport sink (input valid, result_kind, wheel_speed_a, wheel_speed_b, wheel_speed_c,
                 pose_x, pose_y, heading, output ready);
endinterface

// ===== rtl/odk_ctrl.sv =====
// Controller: sequences wheel speed and odometry work over the datapath.
module odk_ctrl
   import odk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      req_ready = 1'b0;
      cmd.op = OP_NONE;
      cmd.wheel = 2'd0;
      cmd.step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.action == ACTION_TICK) begin
                  cmd.op = OP_ODO_LOAD;
                  state_in = ST_ODO_CORDIC;
                  step_in = '0;
               end else begin
                  cmd.op = OP_CMD_LOAD;
                  state_in = ST_WHEEL_A;
               end
            end
         end
         ST_WHEEL_A: begin
            cmd.op = OP_WHEEL_SUM;
            cmd.wheel = 2'd0;
            state_in = ST_WHEEL_B;
         end
         ST_WHEEL_B: begin
            cmd.op = OP_WHEEL_SUM;
            cmd.wheel = 2'd1;
            state_in = ST_WHEEL_C;
         end
         ST_WHEEL_C: begin
            cmd.op = OP_WHEEL_SUM;
            cmd.wheel = 2'd2;
            state_in = ST_WHEEL_SCALE;
            step_in = '0;
         end
         ST_WHEEL_SCALE: begin
            cmd.op = OP_WHEEL_SCALE;
            cmd.wheel = step_ff[1:0];
            step_in = step_ff + 1'b1;
            if (step_ff[1:0] == 2'd2) begin
               state_in = ST_DONE;
            end
         end
         ST_ODO_CORDIC: begin
            cmd.op = OP_CORDIC_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_ODO_MUL_X;
            end
         end
         ST_ODO_MUL_X: begin
            cmd.op = OP_POS_X;
            state_in = ST_ODO_MUL_Y;
         end
         ST_ODO_MUL_Y: begin
            cmd.op = OP_POS_Y;
            state_in = ST_ODO_HEAD;
         end
         ST_ODO_HEAD: begin
            cmd.op = OP_HEAD_MUL;
            state_in = ST_ODO_HEAD_RND;
         end
         ST_ODO_HEAD_RND: begin
            cmd.op = OP_HEAD_ADD;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.op = OP_SEND;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ODO_CORDIC |-> step_ff < STEP_W'(CORDIC_STEPS))
      else $error("cordic step out of range");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_send_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SEND |=> state_ff == ST_IDLE)
      else $error("send did not return to idle");

endmodule

// ===== rtl/odk_datapath.sv =====
// Datapath: kinematics sums, CORDIC rotation, a position multiplier shared by X and Y, and pose state.
module odk_datapath
   import odk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        in_action,
   input  logic [15:0] in_vel_x,
   input  logic [15:0] in_vel_y,
   input  logic [15:0] in_turn_rate,
   input  logic [15:0] in_elapsed,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_kind,
   output logic [23:0] out_wa,
   output logic [23:0] out_wb,
   output logic [23:0] out_wc,
   output logic [31:0] out_px,
   output logic [31:0] out_py,
   output logic [15:0] out_head
);

   logic [15:0] inv_r_ff, base_r_ff;
   logic signed [15:0] vx_ff, vy_ff, om_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [15:0] head_ff;
   logic [15:0] dt_ff;
   logic kind_ff;
   logic signed [37:0] sum_ff [3];
   logic signed [23:0] ws_ff [3];
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [33:0] cz_ff;
   logic signed [47:0] hprod_ff;
   logic out_valid_ff;
   logic out_kind_ff;
   logic [23:0] owa_ff, owb_ff, owc_ff;
   logic [31:0] opx_ff, opy_ff;
   logic [15:0] ohead_ff;

   // wheel projection
   logic signed [17:0] coef_x, coef_y;
   logic signed [37:0] wsum;
   always_comb begin
      unique case (cmd.wheel)
         2'd0: begin coef_x = -COEF_SQRT3_HALF; coef_y = COEF_HALF; end
         2'd1: begin coef_x = 18'sd0; coef_y = -COEF_SQRT3_HALF; end
         default: begin coef_x = COEF_SQRT3_HALF; coef_y = COEF_HALF; end
      endcase
      wsum = 38'(coef_x) * 38'(vx_ff) + 38'(coef_y) * 38'(vy_ff)
           + 38'($signed({1'b0, base_r_ff})) * 38'(om_ff);
   end

   // wheel scale: sum * inv_r, round 24, saturate 24
   logic signed [37:0] wsel;
   logic signed [55:0] wprod;
   logic signed [31:0] wrnd;
   logic signed [23:0] wsat;
   always_comb begin
      wsel = sum_ff[cmd.wheel == 2'd3 ? 2'd2 : cmd.wheel];
      wprod = 56'(wsel) * 56'($signed({1'b0, inv_r_ff}));
      wrnd = 32'((wprod + 56'sd8388608) >>> 24);
      if (wrnd > 32'sd8388607) wsat = 24'sh7FFFFF;
      else if (wrnd < -32'sd8388608) wsat = 24'sh800000;
      else wsat = wrnd[23:0];
   end

   // CORDIC start
   logic signed [35:0] x0, y0;
   logic signed [33:0] z0;
   logic [15:0] hfold;
   always_comb begin
      x0 = 36'(vx_ff) * 36'(CORDIC_COMP);
      y0 = 36'(vy_ff) * 36'(CORDIC_COMP);
      hfold = head_ff;
      if (head_ff >= 16'h4000 && head_ff < 16'hC000) begin
         x0 = -x0;
         y0 = -y0;
         hfold = head_ff - 16'h8000;
      end
      z0 = {{2{hfold[15]}}, hfold, 16'h0000};
   end

   // CORDIC iteration
   logic signed [35:0] xs, ys, xn, yn;
   logic signed [33:0] zn, at;
   always_comb begin
      xs = cx_ff >>> cmd.step;
      ys = cy_ff >>> cmd.step;
      at = atan_turn(5'(cmd.step));
      if (!cz_ff[33]) begin
         xn = cx_ff - ys; yn = cy_ff + xs; zn = cz_ff - at;
      end else begin
         xn = cx_ff + ys; yn = cy_ff - xs; zn = cz_ff + at;
      end
   end

   // position update
   logic signed [35:0] psel;
   logic signed [31:0] pcur;
   logic signed [52:0] pprod;
   logic signed [33:0] pdelta, pnew;
   logic signed [31:0] psat;
   always_comb begin
      psel = (cmd.op == OP_POS_Y) ? cy_ff : cx_ff;
      pcur = (cmd.op == OP_POS_Y) ? py_ff : px_ff;
      pprod = 53'(psel) * 53'($signed({1'b0, dt_ff}));
      pdelta = 34'((pprod + 53'sd134217728) >>> 28);
      pnew = 34'(pcur) + pdelta;
      if (pnew > 34'sd2147483647) psat = 32'sh7FFFFFFF;
      else if (pnew < -34'sd2147483648) psat = 32'sh80000000;
      else psat = pnew[31:0];
   end

   // heading: omega*dt first, then times 1/(2pi)
   logic signed [32:0] odt;
   logic signed [78:0] hfull;
   logic [15:0] dphi;
   always_comb begin
      odt = 33'(om_ff) * 33'($signed({1'b0, dt_ff}));
      hfull = 79'(hprod_ff) * 79'($signed({1'b0, INV_TWO_PI_Q32}));
      dphi = 16'((hfull + (79'sd1 <<< 43)) >>> 44);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_r_ff <= INV_WHEEL_RADIUS_RESET;
         base_r_ff <= BASE_RADIUS_RESET;
         vx_ff <= '0; vy_ff <= '0; om_ff <= '0;
         px_ff <= '0; py_ff <= '0; head_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_INV_WHEEL_RADIUS) inv_r_ff <= csr_data;
            else base_r_ff <= csr_data;
         end
         if (cmd.op == OP_SEND) out_valid_ff <= 1'b1;
         else if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         unique case (cmd.op)
            OP_CMD_LOAD: begin
               vx_ff <= in_vel_x; vy_ff <= in_vel_y; om_ff <= in_turn_rate;
            end
            OP_POS_X: px_ff <= psat;
            OP_POS_Y: py_ff <= psat;
            OP_HEAD_ADD: head_ff <= head_ff + dphi;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_CMD_LOAD: kind_ff <= ACTION_COMMAND;
         OP_ODO_LOAD: begin
            kind_ff <= ACTION_TICK;
            dt_ff <= in_elapsed;
         end
         OP_WHEEL_SUM: sum_ff[cmd.wheel == 2'd3 ? 2'd2 : cmd.wheel] <= wsum;
         OP_WHEEL_SCALE: ws_ff[cmd.wheel == 2'd3 ? 2'd2 : cmd.wheel] <= wsat;
         OP_CORDIC_STEP: begin cx_ff <= xn; cy_ff <= yn; cz_ff <= zn; end
         OP_HEAD_MUL: hprod_ff <= 48'(odt);
         OP_SEND: begin
            out_kind_ff <= kind_ff;
            owa_ff <= kind_ff ? 24'd0 : ws_ff[0];
            owb_ff <= kind_ff ? 24'd0 : ws_ff[1];
            owc_ff <= kind_ff ? 24'd0 : ws_ff[2];
            opx_ff <= px_ff; opy_ff <= py_ff; ohead_ff <= head_ff;
         end
         default: ;
      endcase
      if (cmd.op == OP_ODO_LOAD) begin
         cx_ff <= x0; cy_ff <= y0; cz_ff <= z0;
      end
   end

   assign status.action = in_action;
   assign status.out_busy = out_valid_ff && !out_ready;
   assign out_valid = out_valid_ff;
   assign out_kind = out_kind_ff;
   assign out_wa = owa_ff;
   assign out_wb = owb_ff;
   assign out_wc = owc_ff;
   assign out_px = opx_ff;
   assign out_py = opy_ff;
   assign out_head = ohead_ff;

   a_send_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SEND |-> !(out_valid_ff && !out_ready))
      else $error("send over a waiting word");
   a_send_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SEND |=> out_valid_ff)
      else $error("send lost");
   a_tick_wheels: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff |-> owa_ff == 24'd0 && owb_ff == 24'd0 && owc_ff == 24'd0)
      else $error("tick with wheel speeds");

endmodule

// ===== rtl/omni_drive_kinematics_odometry_core.sv =====
// Top level: omni drive inverse kinematics and dead-reckoning odometry core.
//  channel | dir | ports
//  req     | in  | valid/ready, action, vel_x, vel_y, turn_rate, elapsed
//  rsp     | out | valid/ready, result_kind, wheel speeds a/b/c, pose_x, pose_y, heading
//  csr     | in  | write, index, data (16 bit)
// A command runs wheel sums A, B and C, wheel scaling and done; a tick runs the CORDIC
// iterations, X and Y position, heading multiply and add, then done. Reset clears pose
// and stored velocity. A held response word stalls the controller before send.
module omni_drive_kinematics_odometry_core
   import odk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   odk_req_if.sink     req,
   odk_rsp_if.source   rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   odk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   odk_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .in_action    (req.action),
      .in_vel_x     (req.vel_x),
      .in_vel_y     (req.vel_y),
      .in_turn_rate (req.turn_rate),
      .in_elapsed   (req.elapsed),
      .out_valid    (rsp.valid),
      .out_ready    (rsp.ready),
      .out_kind     (rsp.result_kind),
      .out_wa       (rsp.wheel_speed_a),
      .out_wb       (rsp.wheel_speed_b),
      .out_wc       (rsp.wheel_speed_c),
      .out_px       (rsp.pose_x),
      .out_py       (rsp.pose_y),
      .out_head     (rsp.heading)
   );

endmodule

// ===== tb/tb_omni_drive_kinematics_odometry_core.sv =====
// Testbench for the omni drive kinematics and odometry core, checked word by word.
module tb_omni_drive_kinematics_odometry_core;
   import odk_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic        kind;
      logic [23:0] wa;
      logic [23:0] wb;
      logic [23:0] wc;
      logic [31:0] px;
      logic [31:0] py;
      logic [15:0] hd;
   } report_t;

   typedef struct packed {
      logic        act;
      logic [15:0] vx;
      logic [15:0] vy;
      logic [15:0] w;
      logic [15:0] dt;
      logic        typed;
      report_t     rep;
   } drive_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = 16'd0;

   odk_req_if req ();
   odk_rsp_if rsp ();

   omni_drive_kinematics_odometry_core dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // model state
   logic [15:0] inv_r;
   logic [15:0] base_r;
   logic signed [15:0] cmd_vx, cmd_vy, cmd_w;
   longint pos_x, pos_y;
   logic [15:0] head;

   report_t expected_reports[$];
   bit failed = 1'b0;
   bit steady = 1'b0;
   int unsigned cycles = 0;

   longint atan_q32[24] = '{
      536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772,
      166886, 83443, 41721, 20860, 10430, 5215,
      2607, 1303, 651, 325, 162, 81
   };

   drive_row_t directed_rows[] = '{
      '{ACTION_TICK, 16'h1234, 16'h5678, 16'h7fff, 16'hffff, 1'b1,
         '{1'b1, 24'd0, 24'd0, 24'd0, 32'd0, 32'd0, 16'd0}},
      '{ACTION_COMMAND, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b1,
         '{1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 32'd0, 16'd0}},
      '{ACTION_TICK, 16'hffff, 16'h8000, 16'h8000, 16'hffff, 1'b1,
         '{1'b1, 24'd0, 24'd0, 24'd0, 32'd0, 32'd0, 16'd0}},
      '{ACTION_COMMAND, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{ACTION_COMMAND, 16'h8000, 16'h0000, 16'h0000, 16'hffff, 1'b0, '0},
      '{ACTION_COMMAND, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 1'b0, '0},
      '{ACTION_COMMAND, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0, '0},
      '{ACTION_COMMAND, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 1'b0, '0},
      '{ACTION_COMMAND, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0, '0},
      '{ACTION_COMMAND, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, '0},
      '{ACTION_COMMAND, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'hc000, 1'b0, '0},
      '{ACTION_COMMAND, 16'hf000, 16'h1000, 16'hfff0, 16'h0000, 1'b0, '0},
      '{ACTION_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1'b0, '0}
   };

   function automatic longint round_down(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic logic [23:0] wheel_rate(longint cx, longint cy, longint spin);
      longint sum;
      longint scaled;
      sum = cx * longint'(cmd_vx) + cy * longint'(cmd_vy) + spin;
      scaled = round_down(sum * longint'(inv_r), 24);
      return 24'(clamp(scaled, 24));
   endfunction

   function automatic report_t advance_drive(logic act, logic [15:0] vx, logic [15:0] vy,
                                             logic [15:0] w, logic [15:0] dt);
      report_t r;
      longint spin, x, y, z, xs, ys, dphi;
      logic [15:0] hf;
      r = '0;
      r.kind = act;
      if (act == ACTION_COMMAND) begin
         cmd_vx = vx;
         cmd_vy = vy;
         cmd_w = w;
         spin = longint'(base_r) * longint'(cmd_w);
         r.wa = wheel_rate(-longint'(COEF_SQRT3_HALF), longint'(COEF_HALF), spin);
         r.wb = wheel_rate(0, -longint'(COEF_SQRT3_HALF), spin);
         r.wc = wheel_rate(longint'(COEF_SQRT3_HALF), longint'(COEF_HALF), spin);
      end else begin
         x = longint'(cmd_vx) * longint'(CORDIC_COMP);
         y = longint'(cmd_vy) * longint'(CORDIC_COMP);
         if (head >= 16'h4000 && head < 16'hc000) begin
            x = -x;
            y = -y;
            hf = head - 16'h8000;
         end else begin
            hf = head;
         end
         z = longint'($signed(hf)) * 65536;
         for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - atan_q32[i];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + atan_q32[i];
            end
         end
         pos_x = clamp(pos_x + round_down(x * longint'(dt), 28), 32);
         pos_y = clamp(pos_y + round_down(y * longint'(dt), 28), 32);
         dphi = round_down(longint'(cmd_w) * longint'(dt) * longint'(INV_TWO_PI_Q32), 44);
         head = head + dphi[15:0];
      end
      r.px = pos_x[31:0];
      r.py = pos_y[31:0];
      r.hd = head;
      return r;
   endfunction

   task automatic send_word(logic act, logic [15:0] vx, logic [15:0] vy, logic [15:0] w,
                            logic [15:0] dt, logic typed, report_t typed_rep);
      report_t r;
      if (!steady && $urandom_range(99) < 24) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 60) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= act;
      req.vel_x <= vx;
      req.vel_y <= vy;
      req.turn_rate <= w;
      req.elapsed <= dt;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      r = advance_drive(act, vx, vy, w, dt);
      expected_reports.push_back(typed ? typed_rep : r);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == CSR_INV_WHEEL_RADIUS) inv_r = val;
      else base_r = val;
   endtask

   task automatic random_word();
      logic [15:0] vx, vy, w;
      vx = 16'($urandom);
      vy = 16'($urandom);
      w = 16'($urandom);
      if ($urandom_range(9) == 0) vx = $urandom_range(1) ? 16'h7fff : 16'h8000;
      if ($urandom_range(9) == 0) w = $urandom_range(1) ? 16'h7fff : 16'h8000;
      send_word(1'($urandom_range(1)), vx, vy, w, 16'($urandom), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      report_t e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("omni_drive_kinematics_odometry_core verification failed");
         $finish;
      end else begin
         if (!reset && rsp.valid && rsp.ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected response word");
               failed = 1'b1;
            end else begin
               e = expected_reports.pop_front();
               if (rsp.result_kind !== e.kind) begin
                  $error("result_kind exp %0d got %0d", e.kind, rsp.result_kind);
                  failed = 1'b1;
               end
               if (rsp.wheel_speed_a !== e.wa) begin
                  $error("wheel_speed_a exp %h got %h", e.wa, rsp.wheel_speed_a);
                  failed = 1'b1;
               end
               if (rsp.wheel_speed_b !== e.wb) begin
                  $error("wheel_speed_b exp %h got %h", e.wb, rsp.wheel_speed_b);
                  failed = 1'b1;
               end
               if (rsp.wheel_speed_c !== e.wc) begin
                  $error("wheel_speed_c exp %h got %h", e.wc, rsp.wheel_speed_c);
                  failed = 1'b1;
               end
               if (rsp.pose_x !== e.px) begin
                  $error("pose_x exp %h got %h", e.px, rsp.pose_x);
                  failed = 1'b1;
               end
               if (rsp.pose_y !== e.py) begin
                  $error("pose_y exp %h got %h", e.py, rsp.pose_y);
                  failed = 1'b1;
               end
               if (rsp.heading !== e.hd) begin
                  $error("heading exp %h got %h", e.hd, rsp.heading);
                  failed = 1'b1;
               end
            end
         end
         rsp.ready <= steady || ($urandom_range(99) >= 24);
      end
   end

   initial begin
      logic [15:0] cfg_inv[4];
      logic [15:0] cfg_base[4];
      req.valid = 1'b0;
      req.action = ACTION_COMMAND;
      req.vel_x = 16'd0;
      req.vel_y = 16'd0;
      req.turn_rate = 16'd0;
      req.elapsed = 16'd0;
      rsp.ready = 1'b0;
      inv_r = INV_WHEEL_RADIUS_RESET;
      base_r = BASE_RADIUS_RESET;
      cmd_vx = '0;
      cmd_vy = '0;
      cmd_w = '0;
      pos_x = 0;
      pos_y = 0;
      head = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].act, directed_rows[i].vx, directed_rows[i].vy,
                   directed_rows[i].w, directed_rows[i].dt, directed_rows[i].typed,
                   directed_rows[i].rep);
      drain();

      cfg_inv = '{16'hffff, 16'h0000, 16'($urandom), INV_WHEEL_RADIUS_RESET};
      cfg_base = '{16'hffff, 16'h0000, 16'($urandom), BASE_RADIUS_RESET};
      for (int p = 0; p < 4; p++) begin
         drain();
         write_csr(CSR_INV_WHEEL_RADIUS, cfg_inv[p]);
         write_csr(CSR_BASE_RADIUS, cfg_base[p]);
         for (int n = 0; n < 222; n++) begin
            steady = (p == 1 && n < 90);
            random_word();
         end
         steady = 1'b0;
      end

      for (int n = 0; n < 40; n++) random_word();

      drain();
      if (!failed)
         $display("omni_drive_kinematics_odometry_core verification clean");
      else
         $display("omni_drive_kinematics_odometry_core verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/odk_pkg.sv
rtl/odk_if.sv
rtl/odk_ctrl.sv
rtl/odk_datapath.sv
rtl/omni_drive_kinematics_odometry_core.sv
tb/tb_omni_drive_kinematics_odometry_core.sv
